// ===== hw/rtl/qrra_pkg.sv =====
// Shared types, constants and the arctangent step table for the relative rotation angle core.
package qrra_pkg;

  localparam int COMP_WIDTH_DEF  = 16;
  localparam int ACOS_STAGES_DEF = 16;

  // Angle accumulator format: signed, 20 fraction bits.
  localparam int ANGLE_FRAC = 20;
  localparam int ANGLE_W    = 24;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q20 = 24'sd1647099;

  // Output format and limit (2*pi in Q3.12).
  localparam int OUT_W = 16;
  localparam logic signed [OUT_W:0] ANGLE_MAX_Q12 = 17'sd25736;

  // The CORDIC works on cosine and sine scaled up by this many bits.
  localparam int PRESCALE = 16;

  // Quaternion component and product widths.
  localparam int QW     = 16;
  localparam int PROD_W = 2 * QW;
  localparam int SUM_W  = PROD_W + 2;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_REF_W = 2'd0,
    REG_REF_X = 2'd1,
    REG_REF_Y = 2'd2,
    REG_REF_Z = 2'd3
  } reg_idx_t;

  // Sign class of the relative z part, carried alongside the angle computation.
  typedef struct packed {
    logic zero;
    logic neg;
  } zsign_t;

  // atan(2^-i) in Q.20, rounded to nearest; exact powers of two from i = 7 on.
  function automatic logic signed [ANGLE_W-1:0] atan_step(input int i);
    logic signed [ANGLE_W-1:0] v;
    case (i)
      0: v = 24'sd823550;
      1: v = 24'sd486170;
      2: v = 24'sd256879;
      3: v = 24'sd130396;
      4: v = 24'sd65451;
      5: v = 24'sd32757;
      6: v = 24'sd16383;
      default: begin
        if (i <= ANGLE_FRAC) v = ANGLE_W'(24'sd1 <<< (ANGLE_FRAC - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/qrra_front.sv =====
// Front end: quaternion products, relative w and z, cosine rounding and saturation, cosine square.
module qrra_front import qrra_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [QW-1:0]          cur_w,
  input  logic signed [QW-1:0]          cur_x,
  input  logic signed [QW-1:0]          cur_y,
  input  logic signed [QW-1:0]          cur_z,
  input  logic signed [QW-1:0]          ref_w,
  input  logic signed [QW-1:0]          ref_x,
  input  logic signed [QW-1:0]          ref_y,
  input  logic signed [QW-1:0]          ref_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COMP_WIDTH-1:0]  out_c,
  output logic [2*COMP_WIDTH-4:0]       out_csq,
  output zsign_t                        out_zs
);

  localparam int F   = COMP_WIDTH - 2;
  localparam int CW  = COMP_WIDTH;
  localparam int WW  = SUM_W + 2;
  localparam int SH  = (F < 28) ? (28 - F) : 0;
  localparam int LSH = (F >= 28) ? (F - 28) : 0;
  localparam logic signed [WW-1:0] RND   = WW'((64'd1 << SH) >> 1);
  localparam logic signed [WW-1:0] C_ONE = WW'(64'd1 << F);

  // Stage valid bits and advance enables.
  logic [3:0] v;
  logic [4:0] take;

  // Stage 1: products.
  logic signed [PROD_W-1:0] pw0, pw1, pw2, pw3;
  logic signed [PROD_W-1:0] pz0, pz1, pz2, pz3;
  // Stage 2: relative w and z class.
  logic signed [SUM_W-1:0] w_rel;
  zsign_t                  zs2;
  // Stage 3: saturated cosine.
  logic signed [CW-1:0]    c3;
  zsign_t                  zs3;

  logic signed [SUM_W-1:0] w_rel_next, z_rel_next;
  logic signed [WW-1:0]    c_wide;
  logic signed [CW-1:0]    c_next;
  logic signed [2*CW-1:0]  csq_full;

  always_comb begin
    take[4] = out_ready;
    for (int k = 3; k >= 0; k--) begin
      take[k] = !v[k] || take[k+1];
    end
  end

  assign in_ready = take[0];

  always_comb begin
    w_rel_next = SUM_W'(pw0) + SUM_W'(pw1) + SUM_W'(pw2) + SUM_W'(pw3);
    z_rel_next = SUM_W'(pz2) + SUM_W'(pz3) - SUM_W'(pz0) - SUM_W'(pz1);
  end

  // Round half up to F fraction bits (or shift left for wide formats), then saturate to +-1.
  always_comb begin
    c_wide = ((WW'(w_rel) + RND) >>> SH) <<< LSH;
    if (c_wide > C_ONE) c_next = CW'(C_ONE);
    else if (c_wide < -C_ONE) c_next = CW'(-C_ONE);
    else c_next = CW'(c_wide);
  end

  assign csq_full = c3 * c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (take[0]) v[0] <= in_valid;
      if (take[1]) v[1] <= v[0];
      if (take[2]) v[2] <= v[1];
      if (take[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (take[0] && in_valid) begin
      pw0 <= cur_w * ref_w;
      pw1 <= cur_x * ref_x;
      pw2 <= cur_y * ref_y;
      pw3 <= cur_z * ref_z;
      pz0 <= cur_w * ref_z;
      pz1 <= cur_x * ref_y;
      pz2 <= cur_y * ref_x;
      pz3 <= cur_z * ref_w;
    end
    if (take[1] && v[0]) begin
      w_rel    <= w_rel_next;
      zs2.zero <= (z_rel_next == '0);
      zs2.neg  <= z_rel_next[SUM_W-1];
    end
    if (take[2] && v[1]) begin
      c3  <= c_next;
      zs3 <= zs2;
    end
    if (take[3] && v[2]) begin
      out_c   <= c3;
      out_csq <= csq_full[2*F:0];
      out_zs  <= zs3;
    end
  end

  // The last stage holds the cosine, its square and the z class that leave this block.
  assign out_valid = v[3];

endmodule

// ===== hw/rtl/qrra_sqrt_cell.sv =====
// One cell of the digit-by-digit square root chain: one root bit per cell.
module qrra_sqrt_cell import qrra_pkg::*; #(
  parameter int NB   = COMP_WIDTH_DEF - 1,
  parameter int CW   = COMP_WIDTH_DEF,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2*NB-1:0]      in_rad,
  input  logic [NB+2:0]        in_r,
  input  logic [NB-1:0]        in_q,
  input  logic signed [CW-1:0] in_c,
  input  zsign_t               in_zs,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2*NB-1:0]      out_rad,
  output logic [NB+2:0]        out_r,
  output logic [NB-1:0]        out_q,
  output logic signed [CW-1:0] out_c,
  output zsign_t               out_zs
);

  localparam int RW = NB + 3;

  logic [RW-1:0] r_sh, trial, r_next;
  logic          ge;
  logic [NB-1:0] q_next;

  // Bring down the next pair of radicand bits and try the bit 1 for the root.
  always_comb begin
    r_sh   = {in_r[RW-3:0], in_rad[2*NB-1-2*STEP -: 2]};
    trial  = RW'({in_q, 2'b01});
    ge     = (r_sh >= trial);
    r_next = ge ? (r_sh - trial) : r_sh;
    q_next = {in_q[NB-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rad <= in_rad;
      out_r   <= r_next;
      out_q   <= q_next;
      out_c   <= in_c;
      out_zs  <= in_zs;
    end
  end

endmodule

// ===== hw/rtl/qrra_cordic_cell.sv =====
// One vectoring CORDIC cell: rotates toward the x axis and accumulates the angle.
module qrra_cordic_cell import qrra_pkg::*; #(
  parameter int XW   = COMP_WIDTH_DEF + 17,
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [XW-1:0]      in_x,
  input  logic signed [XW-1:0]      in_y,
  input  logic signed [ANGLE_W-1:0] in_ang,
  input  zsign_t                    in_zs,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [XW-1:0]      out_x,
  output logic signed [XW-1:0]      out_y,
  output logic signed [ANGLE_W-1:0] out_ang,
  output zsign_t                    out_zs
);

  localparam logic signed [ANGLE_W-1:0] ATAN = atan_step(STEP);

  logic signed [XW-1:0]      dx, dy, x_next, y_next;
  logic signed [ANGLE_W-1:0] ang_next;

  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    if (in_y > 0) begin
      x_next   = in_x + dx;
      y_next   = in_y - dy;
      ang_next = in_ang + ATAN;
    end else begin
      x_next   = in_x - dx;
      y_next   = in_y + dy;
      ang_next = in_ang - ATAN;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x   <= x_next;
      out_y   <= y_next;
      out_ang <= ang_next;
      out_zs  <= in_zs;
    end
  end

endmodule

// ===== hw/rtl/quaternion_relative_rotation_angle_core.sv =====
// Top level of the relative rotation angle core: register port, pipeline chains and output register.
//
// This core takes one current orientation quaternion (four signed Q2.14 parts) per transaction
// and returns one signed rotation angle in Q3.12 radians per transaction. It forms the relative
// quaternion current * conj(reference), where the reference sits in four registers (ref_w at
// byte address 0x0, ref_x at 0x4, ref_y at 0x8, ref_z at 0xC; identity after reset). The scalar
// part is rounded to COMP_WIDTH-2 fraction bits and saturated to [-1, 1]; the sine is taken as
// an exact integer square root, and a vectoring CORDIC of ACOS_STAGES cells turns the pair into
// the angle acos(c), which is doubled, rounded to Q3.12 and clamped to [0, 2*pi]. The result
// gets the sign of the relative z part, and a relative z of exactly zero gives an angle of zero.
// Throughput is one transaction per clock while the output is not stalled: every stage is a
// register with its own valid bit, and a stage takes new data whenever it is empty or its
// successor moves, so bubbles are squeezed out and input is still accepted while a finished
// angle waits at a stalled output, as long as empty stages remain. The pipeline has four front
// stages (products, sums, cosine rounding, cosine square), COMP_WIDTH-1 square root cells, one
// CORDIC setup stage, ACOS_STAGES CORDIC cells, and the output register. Registers must only be
// written while no transaction is in flight.
module quaternion_relative_rotation_angle_core import qrra_pkg::*; #(
  parameter int COMP_WIDTH  = COMP_WIDTH_DEF,
  parameter int ACOS_STAGES = ACOS_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [QW-1:0]     cur_w,
  input  logic signed [QW-1:0]     cur_x,
  input  logic signed [QW-1:0]     cur_y,
  input  logic signed [QW-1:0]     cur_z,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  signed_angle,
  // Register port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int F  = COMP_WIDTH - 2;
  localparam int CW = COMP_WIDTH;
  localparam int NB = F + 1;          // root bits, the sine reaches 2^F
  localparam int RW = NB + 3;         // square root partial remainder
  localparam int XW = F + 19;         // CORDIC x/y, leaves room for the CORDIC gain
  localparam logic [2*F:0] ONE_SQ = {1'b1, {(2 * F){1'b0}}};

  // ---------------------------------------------------------------------------------------------
  // Reference quaternion registers. The register index is the word address.
  // ---------------------------------------------------------------------------------------------
  logic signed [QW-1:0] ref_w, ref_x, ref_y, ref_z;
  reg_idx_t             reg_idx;

  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_w <= 16'sd16384;
      ref_x <= '0;
      ref_y <= '0;
      ref_z <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_REF_W: ref_w <= pwdata[QW-1:0];
        REG_REF_X: ref_x <= pwdata[QW-1:0];
        REG_REF_Y: ref_y <= pwdata[QW-1:0];
        REG_REF_Z: ref_z <= pwdata[QW-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register sign-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_REF_W: prdata = APB_DW'(ref_w);
      REG_REF_X: prdata = APB_DW'(ref_x);
      REG_REF_Y: prdata = APB_DW'(ref_y);
      REG_REF_Z: prdata = APB_DW'(ref_z);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Square root chain links: link k feeds cell k; link NB is the output of the last cell.
  // ---------------------------------------------------------------------------------------------
  logic [NB:0]          sq_v, sq_rdy;
  logic [2*NB-1:0]      sq_rad [NB+1];
  logic [RW-1:0]        sq_r   [NB+1];
  logic [NB-1:0]        sq_q   [NB+1];
  logic signed [CW-1:0] sq_c   [NB+1];
  zsign_t               sq_zs  [NB+1];

  // ---------------------------------------------------------------------------------------------
  // Front end: products, relative parts, saturated cosine and its square.
  // ---------------------------------------------------------------------------------------------
  logic                 fr_in_ready;
  logic                 fr_valid;
  logic signed [CW-1:0] fr_c;
  logic [2*F:0]         fr_csq;
  zsign_t               fr_zs;

  qrra_front #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (fr_in_ready),
    .cur_w     (cur_w),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .cur_z     (cur_z),
    .ref_w     (ref_w),
    .ref_x     (ref_x),
    .ref_y     (ref_y),
    .ref_z     (ref_z),
    .out_valid (fr_valid),
    .out_ready (sq_rdy[0]),
    .out_c     (fr_c),
    .out_csq   (fr_csq),
    .out_zs    (fr_zs)
  );

  // The input is stalled only when the first front stage is full and cannot move.
  assign in_stall = !fr_in_ready;

  // ---------------------------------------------------------------------------------------------
  // Square root chain: sine = floor(sqrt(1 - c^2)), one root bit per cell.
  // ---------------------------------------------------------------------------------------------

  // The radicand is 2^(2F) - c^2, which never goes negative because |c| <= 1.
  assign sq_v[0]   = fr_valid;
  assign sq_rad[0] = (2 * NB)'(ONE_SQ - fr_csq);
  assign sq_r[0]   = '0;
  assign sq_q[0]   = '0;
  assign sq_c[0]   = fr_c;
  assign sq_zs[0]  = fr_zs;

  for (genvar k = 0; k < NB; k++) begin : g_sqrt
    qrra_sqrt_cell #(
      .NB   (NB),
      .CW   (CW),
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_rad    (sq_rad[k]),
      .in_r      (sq_r[k]),
      .in_q      (sq_q[k]),
      .in_c      (sq_c[k]),
      .in_zs     (sq_zs[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_rad   (sq_rad[k+1]),
      .out_r     (sq_r[k+1]),
      .out_q     (sq_q[k+1]),
      .out_c     (sq_c[k+1]),
      .out_zs    (sq_zs[k+1])
    );
  end

  // ---------------------------------------------------------------------------------------------
  // CORDIC chain links: link i feeds cell i; link ACOS_STAGES is the output of the last cell.
  // ---------------------------------------------------------------------------------------------
  logic [ACOS_STAGES:0]      cd_v, cd_rdy;
  logic signed [XW-1:0]      cd_x   [ACOS_STAGES+1];
  logic signed [XW-1:0]      cd_y   [ACOS_STAGES+1];
  logic signed [ANGLE_W-1:0] cd_ang [ACOS_STAGES+1];
  zsign_t                    cd_zs  [ACOS_STAGES+1];

  // ---------------------------------------------------------------------------------------------
  // CORDIC setup stage. For a negative cosine the vector is pre-rotated by -pi/2, so the
  // accumulator starts at pi/2 and the CORDIC only ever sees the right half plane.
  // ---------------------------------------------------------------------------------------------
  logic                      init_valid;
  logic signed [XW-1:0]      init_x, init_y;
  logic signed [ANGLE_W-1:0] init_ang;
  zsign_t                    init_zs;
  logic                      init_take;
  logic signed [XW-1:0]      s_ext, c_ext;

  assign init_take    = !init_valid || cd_rdy[0];
  assign sq_rdy[NB]   = init_take;
  assign s_ext        = XW'({1'b0, sq_q[NB]}) <<< PRESCALE;
  assign c_ext        = XW'(sq_c[NB]) <<< PRESCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_valid <= 1'b0;
    end else if (init_take) begin
      init_valid <= sq_v[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (init_take && sq_v[NB]) begin
      init_zs <= sq_zs[NB];
      if (sq_c[NB] < 0) begin
        init_x   <= s_ext;
        init_y   <= -c_ext;
        init_ang <= HALF_PI_Q20;
      end else begin
        init_x   <= c_ext;
        init_y   <= s_ext;
        init_ang <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Vectoring CORDIC chain, one micro-rotation per cell.
  // ---------------------------------------------------------------------------------------------
  assign cd_v[0]   = init_valid;
  assign cd_x[0]   = init_x;
  assign cd_y[0]   = init_y;
  assign cd_ang[0] = init_ang;
  assign cd_zs[0]  = init_zs;

  for (genvar i = 0; i < ACOS_STAGES; i++) begin : g_cordic
    qrra_cordic_cell #(
      .XW   (XW),
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cd_v[i]),
      .in_ready  (cd_rdy[i]),
      .in_x      (cd_x[i]),
      .in_y      (cd_y[i]),
      .in_ang    (cd_ang[i]),
      .in_zs     (cd_zs[i]),
      .out_valid (cd_v[i+1]),
      .out_ready (cd_rdy[i+1]),
      .out_x     (cd_x[i+1]),
      .out_y     (cd_y[i+1]),
      .out_ang   (cd_ang[i+1]),
      .out_zs    (cd_zs[i+1])
    );
  end

  // ---------------------------------------------------------------------------------------------
  // Output register: double the angle, round half up to Q3.12, clamp to [0, 2*pi] and apply
  // the sign of the relative z part. This register parts the output from the pipeline, so a
  // stalled result does not hold back the cells behind it while they have bubbles.
  // ---------------------------------------------------------------------------------------------
  logic                      out_take;
  logic signed [ANGLE_W:0]   ang2, ang2_rnd, res_raw;
  logic signed [OUT_W:0]     res_clamp;
  logic signed [OUT_W-1:0]   angle_next;

  assign out_take            = !out_valid || !out_stall;
  assign cd_rdy[ACOS_STAGES] = out_take;

  always_comb begin
    ang2     = {cd_ang[ACOS_STAGES], 1'b0};
    ang2_rnd = ang2 + (ANGLE_W + 1)'(1 << (ANGLE_FRAC - 12 - 1));
    res_raw  = ang2_rnd >>> (ANGLE_FRAC - 12);
    if (res_raw < 0) res_clamp = '0;
    else if (res_raw > (ANGLE_W + 1)'(ANGLE_MAX_Q12)) res_clamp = ANGLE_MAX_Q12;
    else res_clamp = (OUT_W + 1)'(res_raw);
    if (cd_zs[ACOS_STAGES].zero) angle_next = '0;
    else if (cd_zs[ACOS_STAGES].neg) angle_next = -OUT_W'(res_clamp);
    else angle_next = OUT_W'(res_clamp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= cd_v[ACOS_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && cd_v[ACOS_STAGES]) begin
      signed_angle <= angle_next;
    end
  end

endmodule
